[rtl/tsm_pkg.sv]
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types and constants for the two-stack shared memory block.
// ----------------------------------------------------------------------------
package tsm_pkg;

	localparam int DEPTH = 16;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic load;
		logic exec;
	} tsm_cmd_t;

	typedef struct packed {
		logic busy;
	} tsm_stat_t;

endpackage

[rtl/tsm_ctrl.sv]
// ----------------------------------------------------------------------------
// tsm_ctrl
// Request sequencer: take a request, run it through the datapath, hold the
// result until the receiver takes it.
// ----------------------------------------------------------------------------
module tsm_ctrl
	import tsm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output tsm_cmd_t  cmd,
	output tsm_stat_t stat
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign cmd.load  = (state_q == S_IDLE) && in_valid;
	assign cmd.exec  = (state_q == S_EXEC);
	assign stat.busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

`ifndef SYNTHESIS
	a_load_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec) else $error("load not followed by exec");
	a_exec_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid) else $error("exec not followed by result");
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
`endif

endmodule

[rtl/tsm_dp.sv]
// ----------------------------------------------------------------------------
// tsm_dp
// Datapath: request registers, both stack pointers, shared memory and
// result registers.
// ----------------------------------------------------------------------------
module tsm_dp
	import tsm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  tsm_cmd_t           cmd,
	input  logic [1:0]         op,
	input  logic               stack_select,
	input  logic signed [31:0] push_value,
	output logic signed [31:0] read_value,
	output logic [1:0]         status,
	output logic               low_empty,
	output logic               high_empty,
	output logic               full_res
);

	logic [1:0]  op_q;
	logic        sel_q;
	logic [31:0] val_q;

	logic [CW-1:0] low_count_q;
	logic [CW-1:0] high_start_q;

	logic [31:0] mem_q [DEPTH];
	logic [31:0] rd_raw_q;
	logic        rd_en_q;
	logic [1:0]  status_q;

	logic          full;
	logic          lo_empty;
	logic          hi_empty;
	logic          is_push;
	logic          is_read;
	logic          sel_empty;
	logic          wr_ok;
	logic          rd_ok;
	logic [CW-1:0] addr_full;
	logic [AW-1:0] addr;

	assign full      = (low_count_q >= high_start_q);
	assign lo_empty  = (low_count_q == '0);
	assign hi_empty  = (high_start_q >= CW'(DEPTH));
	assign is_push   = (op_q == OP_PUSH);
	assign is_read   = (op_q == OP_POP) || (op_q == OP_PEEK);
	assign sel_empty = sel_q ? hi_empty : lo_empty;
	assign wr_ok     = is_push && !full;
	assign rd_ok     = is_read && !sel_empty;

	always_comb begin
		if (is_push) addr_full = sel_q ? (high_start_q - CW'(1)) : low_count_q;
		else         addr_full = sel_q ? high_start_q : (low_count_q - CW'(1));
	end
	assign addr = addr_full[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			sel_q <= stack_select;
			val_q <= push_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_ok) mem_q[addr] <= val_q;
		if (cmd.exec) rd_raw_q <= mem_q[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_count_q  <= '0;
			high_start_q <= CW'(DEPTH);
			rd_en_q      <= 1'b0;
			status_q     <= ST_OK;
		end else if (cmd.exec) begin
			rd_en_q <= rd_ok;
			if (is_push && full)           status_q <= ST_OVERFLOW;
			else if (is_read && sel_empty) status_q <= ST_UNDERFLOW;
			else                           status_q <= ST_OK;
			if (wr_ok) begin
				if (sel_q) high_start_q <= high_start_q - CW'(1);
				else       low_count_q  <= low_count_q + CW'(1);
			end else if (rd_ok && (op_q == OP_POP)) begin
				if (sel_q) high_start_q <= high_start_q + CW'(1);
				else       low_count_q  <= low_count_q - CW'(1);
			end
		end
	end

	assign read_value = rd_en_q ? $signed(rd_raw_q) : 32'sd0;
	assign status     = status_q;
	assign low_empty  = lo_empty;
	assign high_empty = hi_empty;
	assign full_res   = full;

`ifndef SYNTHESIS
	a_no_cross: assert property (@(posedge clk) disable iff (!arst_n)
		low_count_q <= high_start_q) else $error("stack tops crossed");
	a_high_bound: assert property (@(posedge clk) disable iff (!arst_n)
		high_start_q <= CW'(DEPTH)) else $error("high pointer past end");
	a_low_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && wr_ok && !sel_q) |=> low_count_q == $past(low_count_q) + CW'(1))
		else $error("low push did not advance");
`endif

endmodule

[rtl/two_stacks_shared_memory.sv]
// ----------------------------------------------------------------------------
// two_stacks_shared_memory
// Two stacks in one shared memory, low stack growing up, high stack down.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request: op (push, pop,
//   peek), stack_select and push_value. Output channel (out_valid /
//   out_stall) returns exactly one result per request: read_value, status
//   (ok, overflow, underflow) and the empty and full flags after the request.
//   A request is taken into the request registers, executed in S_EXEC (memory
//   write or registered memory read) and its result presented in S_OUT. The
//   sequencer holds one request at a time: take, execute, present; no new
//   request is taken until the result of the last one has been taken.
//   in_stall is high whenever a request is in flight.
//   A stalled result holds on the outputs until taken; no new request is
//   accepted meanwhile.
//   Reset empties both stacks; memory contents are left as they were and
//   are never returned on read_value before being written.
// ----------------------------------------------------------------------------
module two_stacks_shared_memory
	import tsm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic               stack_select,
	input  logic signed [31:0] push_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] read_value,
	output logic [1:0]         status,
	output logic               low_empty,
	output logic               high_empty,
	output logic               full_res
);

	tsm_cmd_t  cmd;
	tsm_stat_t stat;
	logic      busy;

	assign busy = stat.busy;

	tsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	tsm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (op),
		.stack_select (stack_select),
		.push_value   (push_value),
		.read_value   (read_value),
		.status       (status),
		.low_empty    (low_empty),
		.high_empty   (high_empty),
		.full_res     (full_res)
	);

`ifndef SYNTHESIS
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == busy) else $error("stall does not track busy");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !out_valid) else $error("result repeated");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("request taken during result");
`endif

endmodule

[dv/tsm_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tsm_checker
// Watches both request and result channels of the two-stack block. Every
// accepted request is run through a local model of the two stacks and the
// resulting word, status and flags are queued. Every accepted result is
// compared with the oldest queued entry. Failures are counted for the top.
// ----------------------------------------------------------------------------
module tsm_checker
	import tsm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         op,
	input  logic               stack_select,
	input  logic signed [31:0] push_value,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] read_value,
	input  logic [1:0]         status,
	input  logic               low_empty,
	input  logic               high_empty,
	input  logic               full_res,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0]         status;
		logic               low_empty;
		logic               high_empty;
		logic               full;
	} stack_result_t;

	logic signed [31:0] words [DEPTH];
	logic [CW-1:0]      low_level;
	logic [CW-1:0]      high_top;
	stack_result_t      expected_results [$];
	int                 result_index;

	function automatic stack_result_t serve_request(input logic [1:0] req_op, input logic sel,
			input logic signed [31:0] word);
		stack_result_t res;
		logic          was_full;
		res = '0;
		was_full = low_level >= high_top;
		case (req_op)
			OP_PUSH: begin
				if (was_full) begin
					res.status = ST_OVERFLOW;
				end else if (!sel) begin
					words[low_level] = word;
					low_level++;
				end else begin
					high_top--;
					words[high_top] = word;
				end
			end
			OP_POP, OP_PEEK: begin
				if (!sel) begin
					if (low_level == 0) begin
						res.status = ST_UNDERFLOW;
					end else begin
						res.value = words[low_level - 1];
						if (req_op == OP_POP)
							low_level--;
					end
				end else begin
					if (high_top >= DEPTH) begin
						res.status = ST_UNDERFLOW;
					end else begin
						res.value = words[high_top];
						if (req_op == OP_POP)
							high_top++;
					end
				end
			end
			default: ;
		endcase
		res.low_empty  = low_level == 0;
		res.high_empty = high_top >= DEPTH;
		res.full       = low_level >= high_top;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stack_result_t got;
		stack_result_t want;
		if (!arst_n) begin
			low_level    = '0;
			high_top     = CW'(DEPTH);
			expected_results.delete();
			result_index = 0;
			fail_count   = 0;
			pending      = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{read_value, status, low_empty, high_empty, full_res};
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("checker: result %0d arrived with nothing expected",
							result_index);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"checker: result %0d expected value %0d status %0d ",
								"empty %b/%b full %b, got value %0d status %0d ",
								"empty %b/%b full %b"}, result_index,
								want.value, want.status, want.low_empty, want.high_empty,
								want.full, got.value, got.status, got.low_empty,
								got.high_empty, got.full);
					end
				end
				result_index++;
			end
			if (in_valid && !in_stall)
				expected_results.push_back(serve_request(op, stack_select, push_value));
			pending = expected_results.size();
		end
	end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the two-stack shared memory block. A directed
// pass covers empty-stack pops and peeks, the unused op, extreme words on
// both stacks; random bursts with push-, pop- or balanced mixes then fill
// the memory to overflow and drain it to underflow. Both sides idle at
// random, and the receiver holds off once long enough to back up the block.
// ----------------------------------------------------------------------------
module tb_top;
	import tsm_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 80;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         op;
	logic               stack_select;
	logic signed [31:0] push_value;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] read_value;
	logic [1:0]         status;
	logic               low_empty;
	logic               high_empty;
	logic               full_res;
	int                 fail_count;
	int                 pending;
	int                 sent_count = 0;
	int                 idle_cycles = 0;
	logic               quiet;

	assign quiet = sent_count >= 500 && sent_count < 650;

	always #1 clk = ~clk;

	two_stacks_shared_memory dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.stack_select (stack_select),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_value   (read_value),
		.status       (status),
		.low_empty    (low_empty),
		.high_empty   (high_empty),
		.full_res     (full_res)
	);

	tsm_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.stack_select (stack_select),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_value   (read_value),
		.status       (status),
		.low_empty    (low_empty),
		.high_empty   (high_empty),
		.full_res     (full_res),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	task automatic send_request(input logic [1:0] req_op, input logic sel,
			input logic [31:0] word);
		while (!quiet && $urandom_range(0, 99) < 11) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		op           <= req_op;
		stack_select <= sel;
		push_value   <= word;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_count++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		logic [31:0] corners [4];
		corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
		if ($urandom_range(0, 7) == 0)
			return corners[$urandom_range(0, 3)];
		return $urandom;
	endfunction

	// receiver: random stalls, one long hold-off to back up the block
	initial begin
		bit held;
		held = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && sent_count >= 300) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES)
					@(negedge clk);
			end
			out_stall <= !quiet && $urandom_range(0, 99) < 11;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int          random_items;
		int          push_pct;
		int          favored;
		int          r;
		logic [1:0]  req_op;
		logic        sel;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		op           = OP_PUSH;
		stack_select = 1'b0;
		push_value   = '0;
		repeat (8)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty stacks, unused op, extreme words on both sides
		send_request(OP_POP, 1'b0, 32'h1234_5678);
		send_request(OP_PEEK, 1'b0, '0);
		send_request(OP_POP, 1'b1, '0);
		send_request(OP_PEEK, 1'b1, 32'hffff_ffff);
		send_request(OP_NONE, 1'b0, 32'hdead_beef);
		send_request(OP_NONE, 1'b1, 32'h0);
		send_request(OP_PUSH, 1'b0, 32'h8000_0000);
		send_request(OP_PUSH, 1'b0, 32'h7fff_ffff);
		send_request(OP_PUSH, 1'b1, 32'hffff_ffff);
		send_request(OP_PUSH, 1'b1, 32'h0000_0000);
		send_request(OP_PEEK, 1'b0, '0);
		send_request(OP_PEEK, 1'b1, '0);
		send_request(OP_POP, 1'b0, '0);
		send_request(OP_POP, 1'b1, '0);
		send_request(OP_POP, 1'b0, '0);
		send_request(OP_POP, 1'b1, '0);
		send_request(OP_POP, 1'b0, '0);
		send_request(OP_PEEK, 1'b1, '0);

		// bursts: push-heavy fills to overflow, pop-heavy drains to underflow
		random_items = 0;
		while (random_items < 920) begin
			case ($urandom_range(0, 2))
				0: push_pct = 80;
				1: push_pct = 50;
				default: push_pct = 20;
			endcase
			favored = $urandom_range(0, 2);
			repeat (40) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					req_op = OP_NONE;
				else if (r < push_pct)
					req_op = OP_PUSH;
				else
					req_op = ($urandom_range(0, 99) < 70) ? OP_POP : OP_PEEK;
				if (favored == 2)
					sel = $urandom_range(0, 1);
				else
					sel = ($urandom_range(0, 99) < 85) ? favored[0] : !favored[0];
				send_request(req_op, sel, pick_word());
				random_items++;
			end
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (10)
			@(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
